>>> src/fdx_pkg.sv
// fdx_pkg: shared types and constants for the frame deframer with xor check
// no dependencies
`default_nettype none

package fdx_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_START_BYTE     = 2'd0,
        REG_HEARTBEAT_TYPE = 2'd1,
        REG_MAX_LEN        = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  heartbeat_type;
        logic [10:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  msg_type;
        logic [7:0]  data_byte;
        logic [10:0] payload_len;
    } t_result;

endpackage

`default_nettype wire

>>> src/fdx_parser.sv
// fdx_parser: frame state machine, one received word per accepted cycle
// depends on fdx_pkg
`default_nettype none

module fdx_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire fdx_pkg::t_cfg    i_cfg,
    output logic                  o_res_valid,
    output fdx_pkg::t_result      o_res
);
    import fdx_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_frame_type, n_frame_type;
    logic [15:0] r_frame_len, n_frame_len;
    logic [10:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_xor, n_xor;
    logic        r_is_hb, n_is_hb;

    logic [15:0] len_full;
    logic        len_too_long;
    logic [10:0] left_dec;

    assign len_full     = {r_frame_len[15:8], i_byte};
    assign len_too_long = (len_full > {5'd0, i_cfg.max_len})
                       || (len_full > 16'(MAX_PAYLOAD));
    assign left_dec     = r_bytes_left - 11'd1;

    // next state
    always_comb begin
        unique case (r_phase)
            PH_TYPE:  n_phase = PH_LENHI;
            PH_LENHI: n_phase = PH_LENLO;
            PH_LENLO: begin
                if (len_too_long) begin
                    n_phase = PH_HUNT;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA:  n_phase = (left_dec == 11'd0) ? PH_CHECK : PH_DATA;
            PH_CHECK: n_phase = PH_HUNT;
            default:  n_phase = (i_byte == i_cfg.start_byte) ? PH_TYPE : PH_HUNT;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_frame_type = r_frame_type;
        n_frame_len  = r_frame_len;
        n_bytes_left = r_bytes_left;
        n_xor        = r_xor;
        n_is_hb      = r_is_hb;
        o_res_valid  = 1'b0;
        o_res.kind        = KIND_DATA;
        o_res.msg_type    = r_frame_type;
        o_res.data_byte   = 8'd0;
        o_res.payload_len = r_frame_len[10:0];
        unique case (r_phase)
            PH_TYPE: begin
                n_frame_type = i_byte;
                n_is_hb      = (i_byte == i_cfg.heartbeat_type);
                n_xor        = r_xor ^ i_byte;
            end
            PH_LENHI: begin
                n_frame_len = {i_byte, 8'd0};
                n_xor       = r_xor ^ i_byte;
            end
            PH_LENLO: begin
                n_frame_len = len_full;
                n_xor       = r_xor ^ i_byte;
                if (!len_too_long) begin
                    n_bytes_left = len_full[10:0];
                end
            end
            PH_DATA: begin
                n_xor        = r_xor ^ i_byte;
                n_bytes_left = left_dec;
                o_res_valid  = !r_is_hb;
                o_res.data_byte = i_byte;
            end
            PH_CHECK: begin
                o_res_valid = !r_is_hb;
                o_res.kind  = (i_byte == r_xor) ? KIND_GOOD : KIND_BAD;
            end
            default: begin
                if (i_byte == i_cfg.start_byte) begin
                    n_xor = i_byte;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_frame_type <= '0;
            r_frame_len  <= '0;
            r_bytes_left <= '0;
            r_xor        <= '0;
            r_is_hb      <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_frame_type <= n_frame_type;
            r_frame_len  <= n_frame_len;
            r_bytes_left <= n_bytes_left;
            r_xor        <= n_xor;
            r_is_hb      <= n_is_hb;
        end
    end

endmodule

`default_nettype wire

>>> src/fdx_out_stage.sv
// fdx_out_stage: result register on the master side of the stream
// depends on fdx_pkg
`default_nettype none

module fdx_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire fdx_pkg::t_result i_res,
    input  wire logic             i_ready,
    output logic                  o_space,
    output logic                  o_valid,
    output fdx_pkg::t_result      o_res
);
    import fdx_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> src/frame_deframer_xor_check_core.sv
// frame_deframer_xor_check_core: top level of the length-prefixed frame deframer
// depends on fdx_pkg, fdx_parser, fdx_out_stage
//
// usage:
//   slave stream takes one received byte per word (i_s_tdata[7:0])
//   frames: start byte, type, 16-bit big-endian length, payload, xor check byte
//   master stream gives one word per payload byte (tuser = data kind) and one
//   end word per frame (tuser = good or checksum error); heartbeat frames and
//   overlong frames give no words, non-start bytes while hunting are dropped
//   output: a result word is registered and appears in the cycle after the byte that causes it
//   throughput: one byte per cycle while o_s_tready is high, set by the single frame state register
//   stall: the result register holds its word while i_m_tready is low; the
//   slave side keeps taking bytes while that register is empty or draining
//   reset: synchronous active-low, back to hunting, registers to start byte 0,
//   heartbeat type 0, max length 1024; output valid cleared
//   config: i_cfg_wr_en writes i_cfg_data into register i_cfg_index (0 start byte, 1 heartbeat
//   type, 2 max length); the user must write only while idle; the block does not enforce it
`default_nettype none

module frame_deframer_xor_check_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [7:0] msg_type, [15:8] data_byte, [26:16] payload_len
    output logic [1:0]       o_m_tuser,   // [1:0] kind
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    import fdx_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    space;
    logic    accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte     <= 8'd0;
            r_cfg.heartbeat_type <= 8'd0;
            r_cfg.max_len        <= 11'(MAX_PAYLOAD);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_START_BYTE:     r_cfg.start_byte     <= i_cfg_data[7:0];
                REG_HEARTBEAT_TYPE: r_cfg.heartbeat_type <= i_cfg_data[7:0];
                REG_MAX_LEN:        r_cfg.max_len        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = space;
    assign accept     = i_s_tvalid && space;

    fdx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fdx_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .i_ready (i_m_tready),
        .o_space (space),
        .o_valid (o_m_tvalid),
        .o_res   (out_res)
    );

    assign o_m_tdata = {5'd0, out_res.payload_len, out_res.data_byte, out_res.msg_type};
    assign o_m_tuser = out_res.kind;

`ifndef NO_ASSERTIONS
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid not cleared by reset");

    a_end_word_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != KIND_DATA) |-> (o_m_tdata[15:8] == 8'd0))
        else $error("end word carries a data byte");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[26:16] <= 11'(MAX_PAYLOAD)))
        else $error("payload length above limit on output");
`endif

endmodule

`default_nettype wire
